### src/vtv_pkg.sv
// ----------------------------------------------------------------------------
// vtv_pkg: shared types and constants for the vertex transform block
// Request and result payload structs, configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package vtv_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0   = 3'd0,
    CFG_ROW1   = 3'd1,
    CFG_ROW2   = 3'd2,
    CFG_ROW3   = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] in_z;
    logic signed [31:0] in_y;
    logic signed [31:0] in_x;
  } vtx_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] clip_w;
    logic signed [31:0] depth;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_x;
  } vtx_out_t;

endpackage
`default_nettype wire

### src/vtv_front.sv
// ----------------------------------------------------------------------------
// vtv_front: matrix multiply front end
// Computes the four homogeneous columns: x, y and z products per lane, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_front #(
  parameter int unsigned CoordFracBits = 16,
  parameter int unsigned AccW = 72
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wire                  adv_i,
  input  wire vtv_pkg::vtx_in_t in_i,
  input  wire [63:0]           row0_i,
  input  wire [63:0]           row1_i,
  input  wire [63:0]           row2_i,
  input  wire [63:0]           row3_i,
  output logic                 valid_o,
  output logic signed [AccW-1:0] acc_o [4]
);
  import vtv_pkg::*;

  // stage 1: products
  logic               v1_q;
  logic signed [47:0] px_q [4];
  logic signed [47:0] py_q [4];
  logic signed [47:0] pz_q [4];
  logic signed [15:0] t_q [4];
  logic signed [AccW-1:0] acc_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 4; k++) begin
        px_q[k] <= in_i.in_x * $signed(row0_i[16*k +: 16]);
        py_q[k] <= in_i.in_y * $signed(row1_i[16*k +: 16]);
        pz_q[k] <= in_i.in_z * $signed(row2_i[16*k +: 16]);
        t_q[k]  <= $signed(row3_i[16*k +: 16]);
      end
      for (int k = 0; k < 4; k++) begin
        acc_q[k] <= AccW'(px_q[k]) + AccW'(py_q[k]) + AccW'(pz_q[k])
                  + (AccW'(t_q[k]) <<< CoordFracBits);
      end
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

### src/vtv_div.sv
// ----------------------------------------------------------------------------
// vtv_div: pipelined restoring divider
// One quotient bit per stage; magnitude quotient clamped to the NDC limit.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_div #(
  parameter int unsigned NumW = 72,
  parameter int unsigned FracBits = 16,
  parameter int unsigned QW = 35
) (
  input  wire             clk_i,
  input  wire             adv_i,
  input  wire [NumW-1:0]  num_i,
  input  wire [NumW-1:0]  den_i,
  output logic [QW-1:0]   quo_o
);
  // quotient of (num << FracBits) / den, kept to QW bits with an overflow flag
  localparam int unsigned Steps = NumW + FracBits;
  localparam int unsigned RemW  = NumW + 1;

  logic [RemW-1:0]  rem_q [1:Steps];
  logic [Steps-1:0] dvd_q [1:Steps];
  logic [NumW-1:0]  den_q [1:Steps];
  logic [QW-1:0]    quo_q [1:Steps];
  logic             ovf_q [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW-1:0]  rem_c;
    logic [Steps-1:0] dvd_c;
    logic [NumW-1:0]  den_c;
    logic [QW-1:0]    quo_c;
    logic             ovf_c;
    logic [RemW-1:0]  sh;
    logic             ge;
    if (s == 0) begin : g_head
      assign rem_c = '0;
      assign dvd_c = {num_i, FracBits'(0)};
      assign den_c = den_i;
      assign quo_c = '0;
      assign ovf_c = 1'b0;
    end else begin : g_body
      assign rem_c = rem_q[s];
      assign dvd_c = dvd_q[s];
      assign den_c = den_q[s];
      assign quo_c = quo_q[s];
      assign ovf_c = ovf_q[s];
    end
    assign sh = {rem_c[NumW-1:0], dvd_c[Steps-1]};
    assign ge = sh >= {1'b0, den_c};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1] <= ge ? sh - {1'b0, den_c} : sh;
        dvd_q[s+1] <= dvd_c << 1;
        den_q[s+1] <= den_c;
        quo_q[s+1] <= {quo_c[QW-2:0], ge};
        ovf_q[s+1] <= ovf_c | quo_c[QW-1];
      end
    end
  end

  localparam logic [QW-1:0] Lim = QW'(1) << (QW-1);
  assign quo_o = (ovf_q[Steps] || quo_q[Steps] >= Lim) ? Lim : quo_q[Steps];
endmodule
`default_nettype wire

### src/vtv_back.sv
// ----------------------------------------------------------------------------
// vtv_back: perspective divide and viewport mapping
// Three dividers in lockstep, then viewport scale, saturate and visibility.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_back #(
  parameter int unsigned CoordFracBits = 16,
  parameter int unsigned CoefFracBits = 10,
  parameter int unsigned AccW = 72
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wire                  adv_i,
  input  wire signed [AccW-1:0] acc_i [4],
  input  wire [12:0]           width_i,
  input  wire [12:0]           height_i,
  output logic                 valid_o,
  output vtv_pkg::vtx_out_t    res_o
);
  import vtv_pkg::*;

  localparam int unsigned QW = 35;
  localparam int unsigned Lat = AccW + CoordFracBits;

  logic [AccW-1:0] mag [4];
  logic            neg [4];
  for (genvar k = 0; k < 4; k++) begin : g_abs
    assign neg[k] = acc_i[k][AccW-1];
    assign mag[k] = neg[k] ? AccW'(-acc_i[k]) : acc_i[k];
  end

  logic [QW-1:0] quo [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    vtv_div #(.NumW(AccW), .FracBits(CoordFracBits), .QW(QW)) u_div (
      .clk_i, .adv_i, .num_i(mag[k]), .den_i(mag[3]), .quo_o(quo[k])
    );
  end

  // side band delayed alongside dividers
  logic [Lat:1]        vld_q;
  logic [2:0]          sgn_q [1:Lat];
  logic                wz_q  [1:Lat];
  logic signed [31:0]  w_q   [1:Lat];
  logic [12:0]         wd_q  [1:Lat];
  logic [12:0]         ht_q  [1:Lat];

  logic signed [AccW-1:0] wsh;
  logic [2:0]             sgn_d;
  logic                   wz_d;
  logic signed [31:0]     w_d;
  assign wsh = acc_i[3] >>> CoefFracBits;

  always_comb begin
    wz_d = (acc_i[3] == '0);
    for (int k = 0; k < 3; k++) begin
      sgn_d[k] = wz_d ? neg[k] : (neg[k] ^ neg[3]);
    end
    if (wsh > AccW'(32'sh7fffffff))       w_d = 32'sh7fffffff;
    else if (wsh < -AccW'(33'sh80000000)) w_d = 32'sh80000000;
    else                                 w_d = wsh[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[Lat-1:1], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sgn_q[1] <= sgn_d;
      wz_q[1]  <= wz_d;
      w_q[1]   <= w_d;
      wd_q[1]  <= width_i;
      ht_q[1]  <= height_i;
    end
  end

  for (genvar s = 1; s < Lat; s++) begin : g_sb
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sgn_q[s+1] <= sgn_q[s];
        wz_q[s+1]  <= wz_q[s];
        w_q[s+1]   <= w_q[s];
        wd_q[s+1]  <= wd_q[s];
        ht_q[s+1]  <= ht_q[s];
      end
    end
  end

  // divide by zero gives the clamp; the divider already yields that for den 0
  localparam logic [QW-1:0] Lim = QW'(1) << (QW-1);
  logic signed [QW:0] nd [3];
  for (genvar k = 0; k < 3; k++) begin : g_sgn
    logic [QW-1:0] m;
    assign m = wz_q[Lat] ? Lim : quo[k];
    assign nd[k] = sgn_q[Lat][k] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  end

  // stage A: viewport terms
  localparam int unsigned TW = QW + 2;
  localparam int unsigned PW = TW + 14;
  logic signed [TW-1:0] tx_q, ty_q;
  logic signed [QW:0]   nz_q;
  logic signed [13:0]   wdA_q, htA_q;
  logic                 wzA_q, vA_q;
  logic signed [31:0]   wA_q;
  // stage B: products
  logic signed [PW-1:0] px_q, py_q;
  logic signed [QW:0]   nzB_q;
  logic signed [13:0]   wdB_q, htB_q;
  logic                 wzB_q, vB_q;
  logic signed [31:0]   wB_q;

  localparam logic signed [TW-1:0] One = TW'(1) << CoordFracBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
    end else if (adv_i) begin
      vA_q <= vld_q[Lat];
      vB_q <= vA_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tx_q  <= One + TW'(nd[0]);
      ty_q  <= One - TW'(nd[1]);
      nz_q  <= nd[2];
      wdA_q <= $signed({1'b0, wd_q[Lat]});
      htA_q <= $signed({1'b0, ht_q[Lat]});
      wzA_q <= wz_q[Lat];
      wA_q  <= w_q[Lat];
      px_q  <= (PW'(tx_q) * PW'(wdA_q)) >>> 1;
      py_q  <= (PW'(ty_q) * PW'(htA_q)) >>> 1;
      nzB_q <= nz_q;
      wdB_q <= wdA_q;
      htB_q <= htA_q;
      wzB_q <= wzA_q;
      wB_q  <= wA_q;
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [PW-1:0] v);
    if (v > PW'(32'sh7fffffff))       return 32'sh7fffffff;
    else if (v < -PW'(33'sh80000000)) return 32'sh80000000;
    else                              return v[31:0];
  endfunction

  logic signed [PW-1:0] wlim, hlim;
  assign wlim = PW'(wdB_q) <<< CoordFracBits;
  assign hlim = PW'(htB_q) <<< CoordFracBits;

  always_comb begin
    valid_o        = vB_q;
    res_o.screen_x = sat(px_q);
    res_o.screen_y = sat(py_q);
    res_o.depth    = sat(PW'(nzB_q));
    res_o.clip_w   = wzB_q ? 32'sd0 : wB_q;
    res_o.visible  = !wzB_q && px_q >= 0 && px_q <= wlim && py_q >= 0 && py_q <= hlim;
  end
endmodule
`default_nettype wire

### src/vertex_transform_viewport.sv
// ----------------------------------------------------------------------------
// vertex_transform_viewport: perspective vertex transform and viewport map
// Row vector times 4x4 matrix, perspective divide, viewport mapping.
// ----------------------------------------------------------------------------
// Pipeline: 2 matrix multiply stages, 88 divider stages, 2 viewport stages,
// then the output queue. Throughput: one request per clock while in_stall_o
// is low; the whole datapath is a stall-gated pipeline, and a 2-deep output
// skid lets input keep flowing after stall rises until the skid is full.
// Reset clears valid flags and loads identity matrix, 640x480.
`default_nettype none
module vertex_transform_viewport #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned COEF_FRAC_BITS = 10
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire vtv_pkg::vtx_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output vtv_pkg::vtx_out_t    out_data_o,
  input  wire                  cfg_we_i,
  input  wire [vtv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [vtv_pkg::CfgDataW-1:0] cfg_data_i
);
  import vtv_pkg::*;

  localparam int unsigned AccW = 72;

  // configuration registers
  logic [63:0] row_q [4];
  logic [12:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'd1024;
      row_q[1] <= 64'd1024 << 16;
      row_q[2] <= 64'd1024 << 32;
      row_q[3] <= 64'd1024 << 48;
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW0:   row_q[0] <= cfg_data_i;
        CFG_ROW1:   row_q[1] <= cfg_data_i;
        CFG_ROW2:   row_q[2] <= cfg_data_i;
        CFG_ROW3:   row_q[3] <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i[12:0];
        CFG_HEIGHT: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid queue is full
  logic [1:0] cnt_q;
  logic       adv;
  assign adv = (cnt_q != 2'd2);
  assign in_stall_o = !adv;

  logic                   f_valid;
  logic signed [AccW-1:0] acc [4];

  vtv_front #(.CoordFracBits(COORD_FRAC_BITS), .AccW(AccW)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .adv_i(adv), .in_i(in_data_i),
    .row0_i(row_q[0]), .row1_i(row_q[1]), .row2_i(row_q[2]), .row3_i(row_q[3]),
    .valid_o(f_valid), .acc_o(acc)
  );

  logic     b_valid;
  vtx_out_t b_res;

  vtv_back #(.CoordFracBits(COORD_FRAC_BITS), .CoefFracBits(COEF_FRAC_BITS),
             .AccW(AccW)) u_back (
    .clk_i, .rst_ni, .valid_i(f_valid), .adv_i(adv), .acc_i(acc),
    .width_i(width_q), .height_i(height_q), .valid_o(b_valid), .res_o(b_res)
  );

  // two-entry output queue
  vtx_out_t q_mem [2];
  logic     wp_q, rp_q;
  logic     push, pop;
  assign push = adv && b_valid;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= b_res;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = q_mem[rp_q];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> cnt_q == 2'd2) else $error("stall without full queue");
endmodule
`default_nettype wire
